// File: design/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; the parser, output buffer and core refer to this package by scoped names.
`default_nettype none

package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0   = 3'd0,
        PH_HDR1   = 3'd1,
        PH_EXT    = 3'd2,
        PH_MASK   = 3'd3,
        PH_DATA   = 3'd4,
        PH_CLOSED = 3'd5
    } phase_t;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    localparam logic [3:0] OPC_CLOSE     = 4'h8;
    localparam logic [6:0] LEN_EXT16     = 7'd126;
    localparam logic [6:0] LEN_EXT64     = 7'd127;
    localparam logic [3:0] EXT16_BYTES   = 4'd2;
    localparam logic [3:0] EXT64_BYTES   = 4'd8;
    localparam logic [2:0] XOR_KEY_BYTES = 3'd4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_out;
        logic [3:0] frame_opcode;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

// File: design/wsd_in_if.sv
// Handshake channel for received stream bytes.
// Depends on nothing; used by the deframer top level.
`default_nettype none

interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       clear;

    modport source (output valid, output byte_in, output clear, input ready);
    modport sink   (input valid, input byte_in, input clear, output ready);
endinterface

`default_nettype wire

// File: design/wsd_out_if.sv
// Handshake channel for deframer results.
// Depends on nothing; used by the deframer top level.
`default_nettype none

interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_out;
    logic [3:0] frame_opcode;
    logic       last;

    modport source (output valid, output kind, output data_out, output frame_opcode,
                    output last, input ready);
    modport sink   (input valid, input kind, input data_out, input frame_opcode,
                    input last, output ready);
endinterface

`default_nettype wire

// File: design/wsd_parser.sv
// Frame header parser, length counter and unmasking for the deframer.
// Depends on wsd_pkg.
`default_nettype none

module wsd_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      byte_in,
    input  wire logic            clear,
    output wsd_pkg::result_t     res,
    output logic                 res_valid
);

    wsd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  cur_opcode_reg, cur_opcode_next;
    logic        mask_on_reg, mask_on_next;
    logic [3:0]  ext_bytes_left_reg, ext_bytes_left_next;
    logic [63:0] remaining_len_reg, remaining_len_next;
    logic [31:0] xor_key_reg, xor_key_next;
    logic [2:0]  mask_bytes_left_reg, mask_bytes_left_next;
    logic [1:0]  key_index_reg, key_index_next;

    logic [6:0]  len7;
    logic [7:0]  key_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= wsd_pkg::PH_HDR0;
            cur_opcode_reg      <= '0;
            mask_on_reg         <= 1'b0;
            ext_bytes_left_reg  <= '0;
            remaining_len_reg   <= '0;
            xor_key_reg         <= '0;
            mask_bytes_left_reg <= '0;
            key_index_reg       <= '0;
        end
        else
        begin
            phase_reg           <= phase_next;
            cur_opcode_reg      <= cur_opcode_next;
            mask_on_reg         <= mask_on_next;
            ext_bytes_left_reg  <= ext_bytes_left_next;
            remaining_len_reg   <= remaining_len_next;
            xor_key_reg         <= xor_key_next;
            mask_bytes_left_reg <= mask_bytes_left_next;
            key_index_reg       <= key_index_next;
        end
    end

    assign len7 = byte_in[6:0];

    always_comb
    begin
        case (key_index_reg)
            2'd0:    key_byte = xor_key_reg[31:24];
            2'd1:    key_byte = xor_key_reg[23:16];
            2'd2:    key_byte = xor_key_reg[15:8];
            default: key_byte = xor_key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next           = phase_reg;
        cur_opcode_next      = cur_opcode_reg;
        mask_on_next         = mask_on_reg;
        ext_bytes_left_next  = ext_bytes_left_reg;
        remaining_len_next   = remaining_len_reg;
        xor_key_next         = xor_key_reg;
        mask_bytes_left_next = mask_bytes_left_reg;
        key_index_next       = key_index_reg;
        res_valid            = 1'b0;
        res.kind             = wsd_pkg::KIND_EMPTY;
        res.data_out         = 8'd0;
        res.frame_opcode     = cur_opcode_reg;
        res.last             = 1'b1;

        if (accept)
        begin
            if (clear)
            begin
                phase_next           = wsd_pkg::PH_HDR0;
                cur_opcode_next      = '0;
                mask_on_next         = 1'b0;
                ext_bytes_left_next  = '0;
                remaining_len_next   = '0;
                xor_key_next         = '0;
                mask_bytes_left_next = '0;
                key_index_next       = '0;
            end
            else
            begin
                case (phase_reg)
                    wsd_pkg::PH_HDR1:
                    begin
                        mask_on_next = byte_in[7];
                        if (cur_opcode_reg == wsd_pkg::OPC_CLOSE)
                        begin
                            phase_next = wsd_pkg::PH_CLOSED;
                            res_valid  = 1'b1;
                            res.kind   = wsd_pkg::KIND_CLOSE;
                        end
                        else if (len7 == wsd_pkg::LEN_EXT16)
                        begin
                            remaining_len_next  = '0;
                            ext_bytes_left_next = wsd_pkg::EXT16_BYTES;
                            phase_next          = wsd_pkg::PH_EXT;
                        end
                        else if (len7 == wsd_pkg::LEN_EXT64)
                        begin
                            remaining_len_next  = '0;
                            ext_bytes_left_next = wsd_pkg::EXT64_BYTES;
                            phase_next          = wsd_pkg::PH_EXT;
                        end
                        else
                        begin
                            remaining_len_next = {57'd0, len7};
                            if (byte_in[7])
                            begin
                                mask_bytes_left_next = wsd_pkg::XOR_KEY_BYTES;
                                phase_next           = wsd_pkg::PH_MASK;
                            end
                            else if (len7 == 7'd0)
                            begin
                                phase_next = wsd_pkg::PH_HDR0;
                                res_valid  = 1'b1;
                            end
                            else
                            begin
                                key_index_next = '0;
                                phase_next     = wsd_pkg::PH_DATA;
                            end
                        end
                    end

                    wsd_pkg::PH_EXT:
                    begin
                        remaining_len_next  = {remaining_len_reg[55:0], byte_in};
                        ext_bytes_left_next = ext_bytes_left_reg - 4'd1;
                        if (ext_bytes_left_next == 4'd0)
                        begin
                            if (mask_on_reg)
                            begin
                                mask_bytes_left_next = wsd_pkg::XOR_KEY_BYTES;
                                phase_next           = wsd_pkg::PH_MASK;
                            end
                            else if (remaining_len_next == 64'd0)
                            begin
                                phase_next = wsd_pkg::PH_HDR0;
                                res_valid  = 1'b1;
                            end
                            else
                            begin
                                key_index_next = '0;
                                phase_next     = wsd_pkg::PH_DATA;
                            end
                        end
                    end

                    wsd_pkg::PH_MASK:
                    begin
                        xor_key_next         = {xor_key_reg[23:0], byte_in};
                        mask_bytes_left_next = mask_bytes_left_reg - 3'd1;
                        if (mask_bytes_left_next == 3'd0)
                        begin
                            key_index_next = '0;
                            if (remaining_len_reg == 64'd0)
                            begin
                                phase_next = wsd_pkg::PH_HDR0;
                                res_valid  = 1'b1;
                            end
                            else
                            begin
                                phase_next = wsd_pkg::PH_DATA;
                            end
                        end
                    end

                    wsd_pkg::PH_DATA:
                    begin
                        key_index_next     = key_index_reg + 2'd1;
                        remaining_len_next = remaining_len_reg - 64'd1;
                        res_valid          = 1'b1;
                        res.kind           = wsd_pkg::KIND_DATA;
                        res.data_out       = mask_on_reg ? (byte_in ^ key_byte) : byte_in;
                        // The byte is the last one when exactly one remained before it.
                        res.last           = (remaining_len_reg == 64'd1);
                        if (res.last)
                        begin
                            phase_next = wsd_pkg::PH_HDR0;
                        end
                    end

                    wsd_pkg::PH_CLOSED:
                    begin
                        phase_next = wsd_pkg::PH_CLOSED;
                    end

                    default:
                    begin
                        cur_opcode_next = byte_in[3:0];
                        phase_next      = wsd_pkg::PH_HDR1;
                    end
                endcase
            end
        end
    end

    a_result_needs_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> accept)
        else $error("result produced without an input transfer");

    a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && clear |=> phase_reg == wsd_pkg::PH_HDR0 && remaining_len_reg == 64'd0)
        else $error("clear byte did not return the parser to its idle header state");

    a_close_halts: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == wsd_pkg::KIND_CLOSE |=> phase_reg == wsd_pkg::PH_CLOSED)
        else $error("close result not followed by the halted state");

    a_last_byte_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == wsd_pkg::KIND_DATA && res.last |=>
            phase_reg == wsd_pkg::PH_HDR0)
        else $error("last payload byte did not return the parser to header parsing");

    a_closed_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == wsd_pkg::PH_CLOSED |-> !res_valid)
        else $error("result produced while halted after a close frame");

endmodule

`default_nettype wire

// File: design/wsd_out_buf.sv
// Result register with a skid entry, so input ready does not depend on output ready.
// Depends on wsd_pkg.
`default_nettype none

module wsd_out_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             res_valid,
    input  wire wsd_pkg::result_t res,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output wsd_pkg::result_t      out_res
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    wsd_pkg::result_t main_data_reg, main_data_next;
    wsd_pkg::result_t skid_data_reg, skid_data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;

        if (main_valid_reg && out_ready)
        begin
            // Input is stalled while the skid entry is full, so no new result arrives here.
            if (skid_valid_reg)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = res_valid;
                main_data_next  = res;
            end
        end
        else if (res_valid)
        begin
            if (!main_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_data_reg;

endmodule

`default_nettype wire

// File: design/websocket_frame_deframer_core.sv
// WebSocket frame deframer: one received byte per transfer, at most one result per byte.
// Built from wsd_parser and wsd_out_buf; each result is registered before it is offered.
// Throughput: one byte per cycle while results drain; input ready is registered and drops
// only while the skid entry is full, which lasts as long as the output channel stalls.
// Reset (rst_n low, asynchronous): parser waits for a first header byte, all state cleared,
// and the result register and skid entry are empty. Depends on wsd_pkg, the interfaces.
`default_nettype none

module websocket_frame_deframer_core (
    input  wire logic clk,
    input  wire logic rst_n,
    wsd_in_if.sink    stream,
    wsd_out_if.source result
);

    logic             accept;
    logic             in_ready;
    logic             res_valid;
    wsd_pkg::result_t res;
    wsd_pkg::result_t out_res;

    assign stream.ready = in_ready;
    assign accept       = stream.valid && in_ready;

    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .byte_in   (stream.byte_in),
        .clear     (stream.clear),
        .res       (res),
        .res_valid (res_valid)
    );

    wsd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (in_ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_res   (out_res)
    );

    assign result.kind         = out_res.kind;
    assign result.data_out     = out_res.data_out;
    assign result.frame_opcode = out_res.frame_opcode;
    assign result.last         = out_res.last;

endmodule

`default_nettype wire

// File: verif/wsd_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the WebSocket frame deframer: a cycle-free model of the frame parser.
// Watches both channels, predicts each result and compares it. Depends on wsd_pkg and
// the channel interfaces.

module wsd_checker (
    input  logic clk,
    input  logic rst_n,
    wsd_in_if    stream,
    wsd_out_if   result,
    output int   errors,
    output int   outstanding
);

    wsd_pkg::phase_t parse_phase = wsd_pkg::PH_HDR0;
    logic [3:0]  frame_opc   = '0;
    logic        masked      = 1'b0;
    logic [3:0]  ext_left    = '0;
    logic [63:0] len_left    = '0;
    logic [31:0] xor_key     = '0;
    logic [2:0]  key_left    = '0;
    logic [1:0]  key_idx     = '0;

    wsd_pkg::result_t expected_q[$];

    initial errors = 0;
    initial outstanding = 0;

    function automatic void clear_parser();
        parse_phase = wsd_pkg::PH_HDR0;
        frame_opc   = '0;
        masked      = 1'b0;
        ext_left    = '0;
        len_left    = '0;
        xor_key     = '0;
        key_left    = '0;
        key_idx     = '0;
    endfunction

    // The length is known; a mask key may still follow.
    function automatic bit length_known(output wsd_pkg::result_t r);
        r = '0;
        if (masked)
        begin
            key_left    = wsd_pkg::XOR_KEY_BYTES;
            parse_phase = wsd_pkg::PH_MASK;
            return 1'b0;
        end
        if (len_left == 64'd0)
        begin
            parse_phase    = wsd_pkg::PH_HDR0;
            r.kind         = wsd_pkg::KIND_EMPTY;
            r.frame_opcode = frame_opc;
            r.last         = 1'b1;
            return 1'b1;
        end
        key_idx     = '0;
        parse_phase = wsd_pkg::PH_DATA;
        return 1'b0;
    endfunction

    // Advances the parser by one byte; returns 1 when the byte yields a result.
    function automatic bit deframe_byte(input logic [7:0] b, input logic clr,
                                        output wsd_pkg::result_t r);
        logic [7:0] key_byte;
        r = '0;
        if (clr)
        begin
            clear_parser();
            return 1'b0;
        end
        case (parse_phase)
            wsd_pkg::PH_HDR1:
            begin
                masked = b[7];
                if (frame_opc == wsd_pkg::OPC_CLOSE)
                begin
                    parse_phase    = wsd_pkg::PH_CLOSED;
                    r.kind         = wsd_pkg::KIND_CLOSE;
                    r.frame_opcode = frame_opc;
                    r.last         = 1'b1;
                    return 1'b1;
                end
                len_left = '0;
                if (b[6:0] == wsd_pkg::LEN_EXT16)
                begin
                    ext_left    = wsd_pkg::EXT16_BYTES;
                    parse_phase = wsd_pkg::PH_EXT;
                    return 1'b0;
                end
                if (b[6:0] == wsd_pkg::LEN_EXT64)
                begin
                    ext_left    = wsd_pkg::EXT64_BYTES;
                    parse_phase = wsd_pkg::PH_EXT;
                    return 1'b0;
                end
                len_left = {57'd0, b[6:0]};
                return length_known(r);
            end
            wsd_pkg::PH_EXT:
            begin
                len_left = {len_left[55:0], b};
                ext_left = ext_left - 4'd1;
                if (ext_left != 4'd0)
                    return 1'b0;
                return length_known(r);
            end
            wsd_pkg::PH_MASK:
            begin
                xor_key  = {xor_key[23:0], b};
                key_left = key_left - 3'd1;
                if (key_left != 3'd0)
                    return 1'b0;
                key_idx = '0;
                if (len_left == 64'd0)
                begin
                    parse_phase    = wsd_pkg::PH_HDR0;
                    r.kind         = wsd_pkg::KIND_EMPTY;
                    r.frame_opcode = frame_opc;
                    r.last         = 1'b1;
                    return 1'b1;
                end
                parse_phase = wsd_pkg::PH_DATA;
                return 1'b0;
            end
            wsd_pkg::PH_DATA:
            begin
                // Key bytes are applied in arrival order, the first one held at the top.
                key_byte = masked ? xor_key[8 * (3 - int'(key_idx)) +: 8] : 8'h00;
                key_idx  = key_idx + 2'd1;
                len_left = len_left - 64'd1;
                r.kind         = wsd_pkg::KIND_DATA;
                r.data_out     = b ^ key_byte;
                r.frame_opcode = frame_opc;
                r.last         = (len_left == 64'd0);
                if (r.last)
                    parse_phase = wsd_pkg::PH_HDR0;
                return 1'b1;
            end
            wsd_pkg::PH_CLOSED:
                return 1'b0;
            default:
            begin
                frame_opc   = b[3:0];
                parse_phase = wsd_pkg::PH_HDR1;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        wsd_pkg::result_t want;
        wsd_pkg::result_t pred;
        if (!rst_n)
        begin
            clear_parser();
            expected_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d data 0x%0h opcode 0x%0h last %0d",
                           result.kind, result.data_out, result.frame_opcode, result.last);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("kind", want.kind, result.kind);
                    check_field("data_out", want.data_out, result.data_out);
                    check_field("frame_opcode", want.frame_opcode, result.frame_opcode);
                    check_field("last", want.last, result.last);
                end
            end
            if (stream.valid && stream.ready)
            begin
                if (deframe_byte(stream.byte_in, stream.clear, pred))
                    expected_q.push_back(pred);
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, byte stimulus and the result-side stall pattern.
// Depends on wsd_pkg, the channel interfaces, the deframer core and wsd_checker.

module testbench;

    localparam int ITEM_TARGET = 1550;
    localparam int CYCLE_LIMIT = 600000;

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   items_sent  = 0;
    int   burst_left  = 0;
    int   cycles      = 0;
    int   ready_mode  = 0;
    int   mode_left   = 0;

    wsd_in_if  stream_ch ();
    wsd_out_if result_ch ();

    websocket_frame_deframer_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .result (result_ch)
    );

    wsd_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .stream      (stream_ch),
        .result      (result_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // The receiver switches between always ready, mostly ready, mostly stalled
    // and long stalls with a periodic release.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(8, 60);
            end
            else
                mode_left <= mode_left - 1;
            case (ready_mode)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                default: result_ch.ready <= (mode_left % 7 == 0);
            endcase
        end
    end

    // One transfer on the input channel. The sender may idle between bursts.
    task automatic send_byte(input logic [7:0] b, input logic clr, input bit counted);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                stream_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        stream_ch.valid   <= 1'b1;
        stream_ch.byte_in <= b;
        stream_ch.clear   <= clr;
        do
            @(posedge clk);
        while (!stream_ch.ready);
        if (counted)
            items_sent++;
    endtask

    task automatic send_seq(input logic [7:0] bytes[$]);
        foreach (bytes[i])
            send_byte(bytes[i], 1'b0, 1'b1);
    endtask

    // Builds one frame. A clear replaces the byte at position cut (none if negative);
    // frames longer than 400 payload bytes are abandoned with a clear after 1 to 20 payload bytes.
    task automatic send_frame(input logic [3:0] opc, input logic masked, input int form,
                              input logic [63:0] len, input int cut);
        logic [7:0]  frame_bytes[$];
        logic [3:0]  upper;
        logic [6:0]  len7;
        logic [31:0] key;
        int          n_payload;
        bit          abandon;
        upper = 4'($urandom_range(0, 15));
        len7  = (form == 0) ? len[6:0] : (form == 1) ? wsd_pkg::LEN_EXT16 : wsd_pkg::LEN_EXT64;
        if (opc == wsd_pkg::OPC_CLOSE)
        begin
            // The block halts after the second header byte; the rest is ignored.
            send_byte({upper, opc}, 1'b0, 1'b1);
            send_byte({masked, len7}, 1'b0, 1'b1);
            repeat ($urandom_range(0, 3))
                send_byte(8'($urandom), 1'b0, 1'b0);
            send_byte(8'($urandom), 1'b1, 1'b1);
            return;
        end
        frame_bytes.push_back({upper, opc});
        frame_bytes.push_back({masked, len7});
        if (form == 1)
        begin
            frame_bytes.push_back(len[15:8]);
            frame_bytes.push_back(len[7:0]);
        end
        else if (form == 2)
        begin
            for (int i = 7; i >= 0; i--)
                frame_bytes.push_back(len[8 * i +: 8]);
        end
        if (masked)
        begin
            key = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom;
            for (int i = 3; i >= 0; i--)
                frame_bytes.push_back(key[8 * i +: 8]);
        end
        abandon   = (len > 64'd400);
        n_payload = abandon ? $urandom_range(1, 20) : int'(len);
        repeat (n_payload)
            frame_bytes.push_back(8'($urandom));
        foreach (frame_bytes[i])
        begin
            if (i == cut)
            begin
                send_byte(8'($urandom), 1'b1, 1'b1);
                return;
            end
            send_byte(frame_bytes[i], 1'b0, 1'b1);
        end
        if (abandon)
            send_byte(8'($urandom), 1'b1, 1'b1);
    endtask

    initial
    begin : stimulus
        logic [7:0]  directed[$];
        logic [3:0]  opc;
        logic        masked;
        logic [63:0] len;
        int          form;
        int          sel;
        int          cut;

        rst_n             = 1'b0;
        stream_ch.valid   = 1'b0;
        stream_ch.byte_in = '0;
        stream_ch.clear   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Clear while idle, then an empty frame with FIN and reserved bits set,
        // a masked frame with extreme key bytes, and a 64-bit length with its top bit set.
        send_byte(8'hFF, 1'b1, 1'b1);
        directed = {8'hF1, 8'h00,
                    8'h8A, 8'h82, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF, 8'h00,
                    8'h00, 8'h7F, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h00, 8'hAA};
        send_seq(directed);
        send_byte(8'h00, 1'b1, 1'b1);
        // Close frame: the trailing byte is ignored until a clear arrives.
        directed = {8'h88, 8'h80, 8'h55};
        send_seq(directed);
        send_byte(8'h00, 1'b1, 1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            sel = $urandom_range(0, 99);
            if (sel >= 90)
            begin
                repeat ($urandom_range(1, 8))
                    send_byte(8'($urandom), ($urandom_range(0, 5) == 0), 1'b1);
                send_byte(8'($urandom), 1'b1, 1'b1);
            end
            else
            begin
                opc    = 4'($urandom_range(0, 15));
                masked = 1'($urandom_range(0, 1));
                form   = $urandom_range(0, 9);
                form   = (form < 6) ? 0 : (form < 9) ? 1 : 2;
                if (form == 0)
                begin
                    sel = $urandom_range(0, 19);
                    len = (sel < 3) ? 64'd0 : (sel == 3) ? 64'd125 : 64'($urandom_range(1, 12));
                end
                else if (form == 1)
                begin
                    sel = $urandom_range(0, 9);
                    len = (sel < 2) ? 64'd0 :
                          (sel < 4) ? 64'($urandom_range(126, 300)) :
                          (sel == 4) ? 64'($urandom_range(0, 65535)) :
                          64'($urandom_range(1, 30));
                end
                else
                begin
                    sel = $urandom_range(0, 5);
                    len = (sel < 2) ? {$urandom, $urandom} :
                          (sel == 2) ? 64'd0 : 64'($urandom_range(1, 30));
                end
                cut = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 14) : -1;
                send_frame(opc, masked, form, len, cut);
            end
        end

        stream_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
design/wsd_pkg.sv
design/wsd_in_if.sv
design/wsd_out_if.sv
design/wsd_parser.sv
design/wsd_out_buf.sv
design/websocket_frame_deframer_core.sv
verif/wsd_checker.sv
verif/testbench.sv
